@@ src/ordered_list_engine_top_defines.svh @@
// Assertion macros for the ordered list engine
`ifndef ORDERED_LIST_ENGINE_TOP_DEFINES_SVH
`define ORDERED_LIST_ENGINE_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define OLE_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("ordered list engine check failed");
// implication checked in the cycle after the antecedent
`define OLE_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("ordered list engine check failed");
`endif

@@ src/ole_pkg.sv @@
// Shared types and codes for the ordered list engine
package ole_pkg;
	localparam int DefCapacity = 32;
	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_INSERT     = 3'd2;
	localparam logic [2:0] OP_POP_FRONT  = 3'd3;
	localparam logic [2:0] OP_POP_BACK   = 3'd4;
	localparam logic [2:0] OP_DELETE     = 3'd5;
	localparam logic [2:0] OP_READ_ALL   = 3'd6;
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_BADPOS   = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] item_value;
		logic [5:0]         position;
	} cmd_t;
	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] out_value;
		logic               last_result;
		logic [5:0]         entry_count;
	} rsp_t;
	// classified command record; the front hands cmd_t, not this type, to the back
	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] item_value;
		logic [6:0]         idx;
	} task_t;
endpackage

@@ src/ole_front.sv @@
// Command acceptance and two-entry queue towards the list back end
module ole_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ole_pkg::cmd_t cmd,
	output logic          busy,
	output logic          q_valid,
	output ole_pkg::cmd_t q_cmd,
	input  logic          q_pop
);
	import ole_pkg::*;
	cmd_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign busy    = cnt_q == 2'd2;
	assign push    = start && !busy;
	assign q_valid = cnt_q != 2'd0;
	assign q_cmd   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

@@ src/ole_back.sv @@
// List store as a row of shift cells plus the command sequencer
module ole_back #(
	parameter int CAPACITY = ole_pkg::DefCapacity
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  ole_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          strobe,
	output ole_pkg::rsp_t rsp
);
	import ole_pkg::*;
	`include "ordered_list_engine_top_defines.svh"
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;

	logic [31:0]   cell_q [CAPACITY];
	logic [CW-1:0] cnt_q;
	logic [1:0]    state_q;
	cmd_t          cmd_q;
	logic [IW-1:0] rd_idx_q;
	logic [CAPACITY-1:0] hit;
	logic [IW-1:0] hit_idx;
	logic          hit_any;
	logic [6:0]    pos_eff;
	logic          do_ins, do_rem;
	logic [IW-1:0] ins_idx, rem_idx;
	logic [2:0]    st;
	logic [31:0]   val;
	rsp_t          rsp_q;
	logic          strobe_q;
	logic          full, empty;

	assign full  = cnt_q >= CW'(CAPACITY);
	assign empty = cnt_q == '0;
	assign q_pop = q_valid && state_q == S_IDLE;

	// parallel match over the cells, first hit wins
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			hit[i] = (i < int'(cnt_q)) && (cell_q[i] == cmd_q.item_value);
			if (hit[i]) begin
				hit_any = 1'b1;
				hit_idx = IW'(i);
			end
		end
	end

	always_comb begin
		pos_eff = (cmd_q.position == '0) ? 7'd1 : {1'b0, cmd_q.position};
		do_ins  = 1'b0;
		do_rem  = 1'b0;
		ins_idx = '0;
		rem_idx = '0;
		st      = ST_OK;
		val     = '0;
		case (cmd_q.opcode)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (full) st = ST_FULL;
				else begin
					do_ins  = 1'b1;
					ins_idx = (cmd_q.opcode == OP_PUSH_FRONT) ? '0 : IW'(cnt_q);
				end
			end
			OP_INSERT: begin
				if (empty) st = ST_EMPTY;
				else if (pos_eff > 7'(cnt_q) + 7'd1) st = ST_BADPOS;
				else if (full) st = ST_FULL;
				else begin
					do_ins  = 1'b1;
					ins_idx = IW'(pos_eff - 7'd1);
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (empty) st = ST_EMPTY;
				else begin
					do_rem  = 1'b1;
					rem_idx = (cmd_q.opcode == OP_POP_FRONT) ? '0 : IW'(cnt_q - CW'(1));
					val     = cell_q[rem_idx];
				end
			end
			OP_DELETE: begin
				if (empty) st = ST_EMPTY;
				else if (!hit_any) st = ST_NOTFOUND;
				else begin
					do_rem  = 1'b1;
					rem_idx = hit_idx;
					val     = cell_q[hit_idx];
				end
			end
			default: st = ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) cmd_q <= q_cmd;
		if (state_q == S_EXEC) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (do_ins) begin
					if (i == int'(ins_idx)) cell_q[i] <= cmd_q.item_value;
					else if (i > int'(ins_idx) && i > 0) cell_q[i] <= cell_q[i-1];
				end else if (do_rem && i >= int'(rem_idx) && i < CAPACITY - 1) begin
					cell_q[i] <= cell_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			rd_idx_q <= '0;
			strobe_q <= 1'b0;
			rsp_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: if (q_pop) state_q <= S_EXEC;
				S_EXEC: begin
					if (cmd_q.opcode == OP_READ_ALL && !empty) begin
						state_q  <= S_READ;
						rd_idx_q <= '0;
					end else begin
						state_q  <= S_IDLE;
						strobe_q <= 1'b1;
						rsp_q.status      <= (cmd_q.opcode == OP_READ_ALL) ? ST_EMPTY : st;
						rsp_q.out_value   <= val;
						rsp_q.last_result <= 1'b1;
						if (do_ins) begin
							cnt_q <= cnt_q + CW'(1);
							rsp_q.entry_count <= 6'(cnt_q + CW'(1));
						end else if (do_rem) begin
							cnt_q <= cnt_q - CW'(1);
							rsp_q.entry_count <= 6'(cnt_q - CW'(1));
						end else rsp_q.entry_count <= 6'(cnt_q);
					end
				end
				S_READ: begin
					strobe_q <= 1'b1;
					rsp_q.status      <= ST_OK;
					rsp_q.out_value   <= cell_q[rd_idx_q];
					rsp_q.entry_count <= 6'(cnt_q);
					rsp_q.last_result <= CW'(rd_idx_q) + CW'(1) == cnt_q;
					rd_idx_q <= rd_idx_q + IW'(1);
					if (CW'(rd_idx_q) + CW'(1) == cnt_q) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign strobe = strobe_q;
	assign rsp    = rsp_q;

	`OLE_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(CAPACITY))
	`OLE_ASSERT_NEXT(a_pop_exec, clk, arst_n, q_pop, state_q == S_EXEC)
	`OLE_ASSERT_NEXT(a_ins_grow, clk, arst_n, state_q == S_EXEC && do_ins,
		cnt_q == $past(cnt_q) + CW'(1))
endmodule

@@ src/ordered_list_engine_top.sv @@
// Per command: queue pop (IDLE), then cell shift/match (EXEC); a read-out adds the READ state.
// Single result commands on an idle engine: start enters the queue, is popped, then executed; the strobe is registered.
// Read-out streams one element per cycle from the cell row, front first.
// A two-word command queue lets start be taken while the back end works.
// The receiver cannot stall: each result word is taken in the cycle it appears.
// arst_n clears the count, queue and sequencer; list cells are not cleared.
module ordered_list_engine_top #(
	parameter int CAPACITY = ole_pkg::DefCapacity
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ole_pkg::cmd_t cmd,
	output logic          busy,
	output logic          strobe,
	output ole_pkg::rsp_t rsp
);
	import ole_pkg::*;
	logic q_valid, q_pop;
	cmd_t q_cmd;

	ole_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
	);

	ole_back #(.CAPACITY(CAPACITY)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_cmd(q_cmd),
		.q_pop(q_pop), .strobe(strobe), .rsp(rsp)
	);
endmodule

@@ dv/ordered_list_engine_top_tb.sv @@
// Testbench for the ordered list engine: queue-fed driver, monitor against a behavioural list
`timescale 1ns / 100ps
module ordered_list_engine_top_tb;
	import ole_pkg::*;

	localparam int Cap = DefCapacity;
	localparam int WatchLimit = 20000;

	logic  clk;
	logic  arst_n;
	logic  start;
	cmd_t  cmd;
	logic  busy;
	logic  strobe;
	rsp_t  rsp;

	ordered_list_engine_top #(.CAPACITY(Cap)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .strobe(strobe), .rsp(rsp)
	);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	cmd_t pending_cmds[$];
	rsp_t expected_rsps[$];
	logic signed [31:0] shadow_list[$];
	int errors = 0;
	int stall_left = 0;
	bit calm = 0;
	bit hold_until_drained = 0;
	int quiet_cycles = 0;

	// behavioural list: work out the words a command produces
	task automatic predict_cmd(input cmd_t c);
		rsp_t r;
		int n, p, hit;
		n = shadow_list.size();
		r = '0;
		r.last_result = 1'b1;
		case (c.opcode)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (n >= Cap) r.status = ST_FULL;
				else if (c.opcode == OP_PUSH_FRONT) shadow_list.push_front(c.item_value);
				else shadow_list.push_back(c.item_value);
			end
			OP_INSERT: begin
				p = (c.position == 0) ? 1 : int'(c.position);
				if (n == 0) r.status = ST_EMPTY;
				else if (p > n + 1) r.status = ST_BADPOS;
				else if (n >= Cap) r.status = ST_FULL;
				else shadow_list.insert(p - 1, c.item_value);
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (n == 0) r.status = ST_EMPTY;
				else if (c.opcode == OP_POP_FRONT) r.out_value = shadow_list.pop_front();
				else r.out_value = shadow_list.pop_back();
			end
			OP_DELETE: begin
				if (n == 0) r.status = ST_EMPTY;
				else begin
					hit = -1;
					for (int i = 0; i < n; i++)
						if (hit < 0 && shadow_list[i] == c.item_value) hit = i;
					if (hit < 0) r.status = ST_NOTFOUND;
					else begin
						r.out_value = shadow_list[hit];
						shadow_list.delete(hit);
					end
				end
			end
			OP_READ_ALL: begin
				if (n == 0) r.status = ST_EMPTY;
				else begin
					for (int i = 0; i < n; i++) begin
						r.out_value = shadow_list[i];
						r.last_result = (i == n - 1);
						r.entry_count = 6'(n);
						expected_rsps.push_back(r);
					end
					return;
				end
			end
			default: ;
		endcase
		r.entry_count = 6'(shadow_list.size());
		expected_rsps.push_back(r);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
		end else begin
			if (start && !busy) predict_cmd(cmd);
			if (start && busy) begin
				// hold the word until taken
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				start <= 1'b0;
			end else if (hold_until_drained && expected_rsps.size() != 0) begin
				start <= 1'b0;
			end else if (pending_cmds.size() != 0 &&
					!(hold_until_drained && start && !busy)) begin
				if (!calm && $urandom_range(0, 9) == 0) begin
					stall_left <= $urandom_range(1, 18) - 1;
					start <= 1'b0;
				end else begin
					cmd <= pending_cmds.pop_front();
					start <= 1'b1;
				end
			end else start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected word status=%0d value=%0d last=%0d count=%0d",
					$time, rsp.status, rsp.out_value, rsp.last_result, rsp.entry_count);
				errors++;
			end else begin
				automatic rsp_t e = expected_rsps.pop_front();
				if (rsp.status !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, rsp.status);
					errors++;
				end
				if (rsp.out_value !== e.out_value) begin
					$display("%0t: value exp %0d got %0d", $time, e.out_value, rsp.out_value);
					errors++;
				end
				if (rsp.last_result !== e.last_result) begin
					$display("%0t: last exp %0d got %0d", $time, e.last_result,
						rsp.last_result);
					errors++;
				end
				if (rsp.entry_count !== e.entry_count) begin
					$display("%0t: count exp %0d got %0d", $time, e.entry_count,
						rsp.entry_count);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || strobe) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchLimit) begin
			$display("ordered_list_engine_top: mismatch");
			$finish;
		end
	end

	function automatic cmd_t mk(input logic [2:0] op, input logic signed [31:0] v,
			input logic [5:0] p);
		cmd_t c;
		c.opcode = op;
		c.item_value = v;
		c.position = p;
		return c;
	endfunction

	function automatic logic signed [31:0] rnd_value();
		case ($urandom_range(0, 3))
			0: return $signed($urandom_range(0, 7)) - 4;
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int fill;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty-list cases, extremes, full list
		pending_cmds.push_back(mk(OP_POP_FRONT, 0, 1));
		pending_cmds.push_back(mk(OP_POP_BACK, 0, 1));
		pending_cmds.push_back(mk(OP_DELETE, 5, 1));
		pending_cmds.push_back(mk(OP_READ_ALL, 0, 1));
		pending_cmds.push_back(mk(OP_INSERT, 9, 1));
		pending_cmds.push_back(mk(3'd7, -1, 63));
		pending_cmds.push_back(mk(OP_PUSH_BACK, 32'sh7fffffff, 0));
		pending_cmds.push_back(mk(OP_PUSH_FRONT, 32'sh80000000, 63));
		pending_cmds.push_back(mk(OP_INSERT, -1, 0));
		pending_cmds.push_back(mk(OP_INSERT, 3, 4));
		pending_cmds.push_back(mk(OP_INSERT, 4, 5));
		pending_cmds.push_back(mk(OP_INSERT, 5, 63));
		pending_cmds.push_back(mk(OP_DELETE, 77, 0));
		pending_cmds.push_back(mk(OP_DELETE, 3, 0));
		pending_cmds.push_back(mk(OP_READ_ALL, 0, 0));
		pending_cmds.push_back(mk(OP_POP_FRONT, 0, 0));
		pending_cmds.push_back(mk(OP_POP_BACK, 0, 0));
		pending_cmds.push_back(mk(OP_POP_BACK, 0, 0));
		pending_cmds.push_back(mk(OP_POP_BACK, 0, 0));
		pending_cmds.push_back(mk(OP_PUSH_BACK, 1, 0));
		pending_cmds.push_back(mk(OP_DELETE, 1, 0));
		for (int i = 0; i < Cap; i++) pending_cmds.push_back(mk(OP_PUSH_BACK, i, 0));
		pending_cmds.push_back(mk(OP_PUSH_FRONT, 1, 0));
		pending_cmds.push_back(mk(OP_INSERT, 1, 33));
		pending_cmds.push_back(mk(OP_INSERT, 1, 34));
		pending_cmds.push_back(mk(OP_READ_ALL, 0, 0));
		wait (pending_cmds.size() == 0 && expected_rsps.size() == 0);

		// pause until drained, then random
		hold_until_drained = 1;
		repeat (20) @(posedge clk);
		hold_until_drained = 0;
		for (int i = 0; i < 300; i++) begin
			fill = $urandom_range(0, 99);
			if (i > 240) calm = 1;
			if (fill < 18)
				pending_cmds.push_back(mk(OP_PUSH_FRONT, rnd_value(), 6'($urandom)));
			else if (fill < 40)
				pending_cmds.push_back(mk(OP_PUSH_BACK, rnd_value(), 6'($urandom)));
			else if (fill < 55)
				pending_cmds.push_back(mk(OP_INSERT, rnd_value(),
					6'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 34))));
			else if (fill < 65)
				pending_cmds.push_back(mk(OP_POP_FRONT, rnd_value(), 6'($urandom)));
			else if (fill < 75)
				pending_cmds.push_back(mk(OP_POP_BACK, rnd_value(), 6'($urandom)));
			else if (fill < 88)
				pending_cmds.push_back(mk(OP_DELETE, rnd_value(), 6'($urandom)));
			else if (fill < 97)
				pending_cmds.push_back(mk(OP_READ_ALL, rnd_value(), 6'($urandom)));
			else
				pending_cmds.push_back(mk(3'd7, rnd_value(), 6'($urandom)));
			while (pending_cmds.size() > 4) @(posedge clk);
		end
		wait (pending_cmds.size() == 0 && !start);
		wait (expected_rsps.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0)
			$display("ordered_list_engine_top: match");
		else
			$display("ordered_list_engine_top: mismatch");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+src
src/ole_pkg.sv
src/ole_front.sv
src/ole_back.sv
src/ordered_list_engine_top.sv
dv/ordered_list_engine_top_tb.sv
